// ----- hw/rtl/ack_retransmit_tracker_unit_macros.svh -----
// Assertion macros for the ack retransmit tracker.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ACK_RETRANSMIT_TRACKER_UNIT_MACROS_SVH
`define ACK_RETRANSMIT_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ART_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ART_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/art_pkg.sv -----
// Shared types and codes for the ack retransmit tracker.
// No dependencies; imported by art_ctrl, art_dp and the top level.
`default_nettype none

package art_pkg;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] EV_ACCEPTED    = 3'd0;
  localparam logic [2:0] EV_FULL        = 3'd1;
  localparam logic [2:0] EV_ACK_OK      = 3'd2;
  localparam logic [2:0] EV_ACK_UNKNOWN = 3'd3;
  localparam logic [2:0] EV_RESEND      = 3'd4;
  localparam logic [2:0] EV_GIVE_UP     = 3'd5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'b1;

  localparam logic [7:0] TIMEOUT_RST = 8'd10;
  localparam logic [3:0] LIMIT_RST   = 4'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  age;
    logic [3:0]  retries;
  } art_slot_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the input transaction
    logic start;      // restart the slot scan
    logic find_run;   // id match / free slot scan
    logic age_run;    // aging pass
    logic min_run;    // smallest expired id scan
    logic emit_find;  // result of a send or ack
    logic emit_tick;  // result for the selected expired entry
  } art_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic any_exp;
    logic more_exp;
    logic out_busy;
  } art_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/art_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module art_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/art_ctrl.sv -----
// Controller FSM of the ack retransmit tracker: sequences scans and results.
// Depends on art_pkg.
`default_nettype none

module art_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_opcode,
  output logic                    in_ready,
  input  wire art_pkg::art_stat_t stat,
  output art_pkg::art_cmd_t       cmd
);
  import art_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_FIND_OUT,
    S_AGE,
    S_MIN,
    S_TICK_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_SEND, OP_ACK: begin
              cmd.start = 1'b1;
              state_nxt = S_FIND;
            end
            OP_TICK: begin
              cmd.start = 1'b1;
              state_nxt = S_AGE;
            end
            default: ;  // undefined opcode: dropped
          endcase
        end
      end
      S_FIND: begin
        cmd.find_run = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FIND_OUT;
        end
      end
      S_FIND_OUT: begin
        if (!stat.out_busy) begin
          cmd.emit_find = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_AGE: begin
        cmd.age_run = 1'b1;
        if (stat.scan_done) begin
          if (stat.any_exp) begin
            cmd.start = 1'b1;
            state_nxt = S_MIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MIN: begin
        cmd.min_run = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_TICK_OUT;
        end
      end
      S_TICK_OUT: begin
        if (!stat.out_busy) begin
          cmd.emit_tick = 1'b1;
          if (stat.more_exp) begin
            cmd.start = 1'b1;
            state_nxt = S_MIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/art_dp.sv -----
// Datapath of the ack retransmit tracker: slot RAM, valid/expired bits,
// scan pipeline, config registers and result register. Uses art_pkg, art_ram.
`default_nettype none

module art_dp #(
  parameter int ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [art_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [art_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [31:0]                   in_message_id,
  input  wire art_pkg::art_cmd_t             cmd,
  output art_pkg::art_stat_t                 stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [2:0]                         out_event_res,
  output logic [31:0]                        out_result_id,
  output logic [3:0]                         out_retry_count,
  output logic                               out_last
);
  import art_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $bits(art_slot_t);

  logic [7:0]         timeout_r;
  logic [3:0]         limit_r;
  logic [1:0]         op_r;
  logic [31:0]        op_id_r;
  logic [CW-1:0]      cnt_r;
  logic               live_r;
  logic [IW-1:0]      ridx_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] exp_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  logic [3:0]         hit_ret_r;
  logic               free_r;
  logic [IW-1:0]      free_idx_r;
  logic               best_r;
  logic [IW-1:0]      best_idx_r;
  art_slot_t          best_slot_r;
  logic               out_valid_r;
  logic [2:0]         out_ev_r;
  logic [31:0]        out_id_r;
  logic [3:0]         out_ret_r;
  logic               out_last_r;

  logic [SW-1:0]      ram_rdata;
  art_slot_t          rd_slot;
  logic               we;
  logic [IW-1:0]      waddr;
  art_slot_t          wdata;
  logic [7:0]         age_inc;
  logic               age_exp;
  logic               give;
  logic [ENTRIES-1:0] best_mask;
  logic [ENTRIES-1:0] exp_left;
  logic               cnt_end;
  logic               send_ok;

  art_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_slot   = art_slot_t'(ram_rdata);
  assign age_inc   = (rd_slot.age == 8'hFF) ? rd_slot.age : rd_slot.age + 8'd1;
  assign age_exp   = (age_inc >= timeout_r);
  assign give      = (best_slot_r.retries >= limit_r);
  assign best_mask = {{(ENTRIES-1){1'b0}}, 1'b1} << best_idx_r;
  assign exp_left  = exp_r & ~best_mask;
  assign cnt_end   = (cnt_r == CW'(ENTRIES));
  assign send_ok   = hit_r || free_r;

  assign stat.scan_done = cnt_end && !live_r;
  assign stat.any_exp   = |exp_r;
  assign stat.more_exp  = |exp_left;
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_ev_r;
  assign out_result_id   = out_id_r;
  assign out_retry_count = out_ret_r;
  assign out_last        = out_last_r;

  // single RAM write port: aging write-back, send store, resend update
  always_comb begin
    we    = 1'b0;
    waddr = ridx_r;
    wdata = rd_slot;
    if (cmd.age_run && live_r && valid_r[ridx_r]) begin
      we        = 1'b1;
      wdata.age = age_inc;
    end
    if (cmd.emit_find && op_r == OP_SEND && send_ok) begin
      we            = 1'b1;
      waddr         = hit_r ? hit_idx_r : free_idx_r;
      wdata.id      = op_id_r;
      wdata.age     = 8'd0;
      wdata.retries = 4'd0;
    end
    if (cmd.emit_tick && !give) begin
      we            = 1'b1;
      waddr         = best_idx_r;
      wdata.id      = best_slot_r.id;
      wdata.age     = 8'd0;
      wdata.retries = best_slot_r.retries + 4'd1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      limit_r     <= LIMIT_RST;
      cnt_r       <= '0;
      live_r      <= 1'b0;
      valid_r     <= '0;
      exp_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      best_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_wdata;
          CFG_LIMIT:   limit_r   <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      if (cmd.start) begin
        cnt_r  <= '0;
        live_r <= 1'b0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        best_r <= 1'b0;
      end else if (cmd.find_run || cmd.age_run || cmd.min_run) begin
        if (!cnt_end) begin
          cnt_r  <= cnt_r + CW'(1);
          live_r <= 1'b1;
        end else begin
          live_r <= 1'b0;
        end
        if (live_r) begin
          if (cmd.find_run) begin
            if (valid_r[ridx_r] && rd_slot.id == op_id_r) begin
              hit_r <= 1'b1;
            end
            if (!valid_r[ridx_r]) begin
              free_r <= 1'b1;
            end
          end
          if (cmd.age_run) begin
            exp_r[ridx_r] <= valid_r[ridx_r] && age_exp;
          end
          if (cmd.min_run && exp_r[ridx_r]) begin
            best_r <= 1'b1;
          end
        end
      end

      if (cmd.emit_find) begin
        if (op_r == OP_SEND) begin
          if (hit_r) begin
            valid_r[hit_idx_r] <= 1'b1;
          end else if (free_r) begin
            valid_r[free_idx_r] <= 1'b1;
          end
        end else if (hit_r) begin
          valid_r[hit_idx_r] <= 1'b0;
        end
      end
      if (cmd.emit_tick) begin
        exp_r[best_idx_r] <= 1'b0;
        if (give) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end

      if (cmd.emit_find || cmd.emit_tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      op_id_r <= in_message_id;
    end
    if (!cmd.start && !cnt_end && (cmd.find_run || cmd.age_run || cmd.min_run)) begin
      ridx_r <= cnt_r[IW-1:0];
    end
    if (live_r && !cmd.start) begin
      if (cmd.find_run) begin
        if (valid_r[ridx_r] && rd_slot.id == op_id_r && !hit_r) begin
          hit_idx_r <= ridx_r;
          hit_ret_r <= rd_slot.retries;
        end
        if (!valid_r[ridx_r] && !free_r) begin
          free_idx_r <= ridx_r;  // lowest free slot wins
        end
      end
      if (cmd.min_run && exp_r[ridx_r] && (!best_r || rd_slot.id < best_slot_r.id)) begin
        best_idx_r  <= ridx_r;
        best_slot_r <= rd_slot;
      end
    end

    if (cmd.emit_find) begin
      out_id_r   <= op_id_r;
      out_last_r <= 1'b1;
      if (op_r == OP_SEND) begin
        out_ev_r  <= send_ok ? EV_ACCEPTED : EV_FULL;
        out_ret_r <= 4'd0;
      end else begin
        out_ev_r  <= hit_r ? EV_ACK_OK : EV_ACK_UNKNOWN;
        out_ret_r <= hit_r ? hit_ret_r : 4'd0;
      end
    end
    if (cmd.emit_tick) begin
      out_id_r   <= best_slot_r.id;
      out_last_r <= ~(|exp_left);
      out_ev_r   <= give ? EV_GIVE_UP : EV_RESEND;
      out_ret_r  <= give ? best_slot_r.retries : best_slot_r.retries + 4'd1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ack_retransmit_tracker_unit.sv -----
// Ack retransmit tracker top level: art_ctrl FSM plus art_dp datapath (art_pkg).
// Send/ack: one pass over the ENTRIES-deep slot RAM, then the result once the output is free.
// Tick: aging pass, then one smallest-id scan and one result per expired entry; one RAM
// read per cycle sets the pace of each scan, and a result that is not taken holds the flow.
// One transaction at a time; the result register lets the next input be taken while it waits.
// Reset (rst_n, synchronous, active low) empties the table and restores timeout 10, limit 3.
`default_nettype none
`include "ack_retransmit_tracker_unit_macros.svh"

module ack_retransmit_tracker_unit #(
  parameter int ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [art_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [31:0]                    in_message_id,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          out_event_res,
  output logic [31:0]                         out_result_id,
  output logic [3:0]                          out_retry_count,
  output logic                                out_last
);
  import art_pkg::*;

  art_cmd_t  cmd;
  art_stat_t stat;

  art_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  art_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_message_id   (in_message_id),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_event_res   (out_event_res),
    .out_result_id   (out_result_id),
    .out_retry_count (out_retry_count),
    .out_last        (out_last)
  );

  // a real operation keeps the input closed while the table is scanned
  `ART_ASSERT_NXT(a_busy_after_op, in_valid && in_ready && (in_opcode == OP_SEND || in_opcode == OP_ACK || in_opcode == OP_TICK), !in_ready, "input ready right after an accepted operation")
  // send and ack produce exactly one result
  `ART_ASSERT_IMP(a_single_last, out_valid && !(out_event_res == EV_RESEND || out_event_res == EV_GIVE_UP), out_last, "send/ack result without last")
  `ART_ASSERT_IMP(a_zero_retry, out_valid && (out_event_res == EV_ACCEPTED || out_event_res == EV_FULL || out_event_res == EV_ACK_UNKNOWN), out_retry_count == 4'd0, "nonzero retry count on send or unknown ack")

endmodule

`default_nettype wire

// ----- sim/ack_retransmit_tracker_unit_checker.sv -----
// Scoreboard for the ack retransmit tracker: mirrors the slot table and thresholds,
// predicts the events of every input transaction and checks the result channel.
// Depends on art_pkg; instantiated next to the block by ack_retransmit_tracker_unit_tb.
module ack_retransmit_tracker_unit_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [art_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [31:0]                    in_message_id,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [2:0]                     out_event_res,
  input  logic [31:0]                    out_result_id,
  input  logic [3:0]                     out_retry_count,
  input  logic                           out_last,
  output int unsigned                    fail_count,
  output int unsigned                    pending,
  output int unsigned                    results_checked,
  output int unsigned                    expiry_events
);
  import art_pkg::*;

  typedef struct packed {
    logic [2:0]  ev;
    logic [31:0] id;
    logic [3:0]  rc;
    logic        last;
  } tracker_event_t;

  tracker_event_t expected_events[$];
  tracker_event_t step_events[$];

  // mirror of the slot table
  logic        slot_live [ENTRIES];
  logic [31:0] slot_id   [ENTRIES];
  logic [7:0]  slot_age  [ENTRIES];
  logic [3:0]  slot_rtr  [ENTRIES];
  logic [7:0]  timeout_cfg;
  logic [3:0]  limit_cfg;

  function automatic int find_slot(input logic [31:0] id);
    int s;
    s = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (s < 0 && slot_live[i] && slot_id[i] == id) s = i;
    return s;
  endfunction

  task automatic note_event(input logic [2:0] ev, input logic [31:0] id,
                            input logic [3:0] rc);
    tracker_event_t e;
    e.ev = ev;
    e.id = id;
    e.rc = rc;
    e.last = 1'b0;
    step_events.insert(step_events.size(), e);
  endtask

  task automatic predict_events(input logic [1:0] op, input logic [31:0] id);
    int s;
    int best;
    logic due [ENTRIES];
    tracker_event_t e;
    case (op)
      OP_SEND: begin
        s = find_slot(id);
        if (s < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && !slot_live[i]) s = i;
        if (s < 0) begin
          note_event(EV_FULL, id, 4'd0);
        end else begin
          slot_live[s] = 1'b1;
          slot_id[s] = id;
          slot_age[s] = 8'd0;
          slot_rtr[s] = 4'd0;
          note_event(EV_ACCEPTED, id, 4'd0);
        end
      end
      OP_ACK: begin
        s = find_slot(id);
        if (s < 0) begin
          note_event(EV_ACK_UNKNOWN, id, 4'd0);
        end else begin
          slot_live[s] = 1'b0;
          note_event(EV_ACK_OK, id, slot_rtr[s]);
        end
      end
      OP_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          due[i] = 1'b0;
          if (slot_live[i]) begin
            if (slot_age[i] != 8'hFF) slot_age[i] = slot_age[i] + 8'd1;
            due[i] = slot_age[i] >= timeout_cfg;
          end
        end
        // expired entries go out smallest id first
        repeat (ENTRIES) begin
          best = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (due[i] && (best < 0 || slot_id[i] < slot_id[best])) best = i;
          if (best >= 0) begin
            due[best] = 1'b0;
            if (slot_rtr[best] >= limit_cfg) begin
              slot_live[best] = 1'b0;
              note_event(EV_GIVE_UP, slot_id[best], slot_rtr[best]);
            end else begin
              slot_rtr[best] = slot_rtr[best] + 4'd1;
              slot_age[best] = 8'd0;
              note_event(EV_RESEND, slot_id[best], slot_rtr[best]);
            end
          end
        end
      end
      default: ;  // reserved opcode leaves everything as is
    endcase
    while (step_events.size() != 0) begin
      e = step_events.pop_front();
      e.last = (step_events.size() == 0);
      expected_events.insert(expected_events.size(), e);
    end
  endtask

  task automatic check_result();
    tracker_event_t e;
    if (expected_events.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result expected none, actual ev=%0d id=%h rc=%0d last=%0b",
               $time, out_event_res, out_result_id, out_retry_count, out_last);
    end else begin
      e = expected_events.pop_front();
      results_checked++;
      if (e.ev == EV_RESEND || e.ev == EV_GIVE_UP) expiry_events++;
      if (out_event_res !== e.ev || out_result_id !== e.id ||
          out_retry_count !== e.rc || out_last !== e.last) begin
        fail_count++;
        $display("%0t: result mismatch expected ev=%0d id=%h rc=%0d last=%0b, actual ev=%0d id=%h rc=%0d last=%0b",
                 $time, e.ev, e.id, e.rc, e.last,
                 out_event_res, out_result_id, out_retry_count, out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
      timeout_cfg = TIMEOUT_RST;
      limit_cfg = LIMIT_RST;
      expected_events.delete();
      fail_count = 0;
      results_checked = 0;
      expiry_events = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_cfg = cfg_wdata[7:0];
          CFG_LIMIT:   limit_cfg = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) predict_events(in_opcode, in_message_id);
    end
    pending = expected_events.size();
  end

endmodule

// ----- sim/ack_retransmit_tracker_unit_tb.sv -----
// Testbench top for ack_retransmit_tracker_unit: clock, reset, directed and random
// send/ack/tick transactions under several thresholds and idle mixes, verdict.
// Depends on art_pkg, the block and ack_retransmit_tracker_unit_checker.
module ack_retransmit_tracker_unit_tb;
  import art_pkg::*;

  localparam int ENTRIES = 16;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 55;
  localparam int POOL_SIZE = 20;
  // worst tick: aging pass plus one scan per expired entry
  localparam int DRAIN_CYCLES = (ENTRIES + 2) * (ENTRIES + 1) + 4 * ENTRIES;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [1:0] OP_RSVD = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_opcode = OP_SEND;
  logic [31:0]             in_message_id = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [2:0]              out_event_res;
  logic [31:0]             out_result_id;
  logic [3:0]              out_retry_count;
  logic                    out_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_checked;
  int unsigned expiry_events;

  int unsigned snd_idle = 11;
  int unsigned rcv_idle = 72;
  int unsigned transactions = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_cnt = 0;

  always #4 clk = ~clk;

  ack_retransmit_tracker_unit #(.ENTRIES(ENTRIES)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_message_id  (in_message_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_result_id  (out_result_id),
    .out_retry_count(out_retry_count),
    .out_last       (out_last)
  );

  ack_retransmit_tracker_unit_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_message_id  (in_message_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_result_id  (out_result_id),
    .out_retry_count(out_retry_count),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .expiry_events  (expiry_events)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("FAIL ack_retransmit_tracker_unit");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_transaction(input logic [1:0] op, input logic [31:0] id);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_message_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    transactions++;
  endtask

  // A tick with nothing expired gives no result, so wait out a full tick as well.
  task automatic drain_tracker();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_thresholds(input logic [7:0] timeout, input logic [3:0] limit);
    drain_tracker();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(timeout);
    @(negedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [31:0] id_pool [POOL_SIZE];
    logic [7:0]  phase_timeout [PHASES];
    logic [3:0]  phase_limit [PHASES];
    logic [31:0] id;
    logic [1:0]  op;
    int unsigned roll;
    int          counted;

    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    phase_timeout[0] = 8'd1;   phase_limit[0] = 4'd0;
    phase_timeout[1] = 8'd2;   phase_limit[1] = 4'd15;
    phase_timeout[2] = 8'd255; phase_limit[2] = 4'd3;
    phase_timeout[3] = 8'd0;   phase_limit[3] = 4'd2;   // zero timeout behaves as one
    phase_timeout[4] = 8'd3;   phase_limit[4] = 4'd1;
    phase_timeout[5] = 8'($urandom_range(1, 8));   phase_limit[5] = 4'($urandom_range(0, 15));
    phase_timeout[6] = 8'($urandom_range(1, 255)); phase_limit[6] = 4'($urandom_range(0, 15));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset thresholds first
    offer_transaction(OP_ACK, 32'h1234_5678);   // unknown ack
    offer_transaction(OP_SEND, 32'h0000_0000);
    offer_transaction(OP_SEND, 32'hFFFF_FFFF);
    offer_transaction(OP_SEND, 32'h0000_0000);  // repeated id overwrites
    offer_transaction(OP_RSVD, 32'hAAAA_AAAA);  // ignored
    offer_transaction(OP_TICK, 32'h5555_5555);  // nothing expires yet
    offer_transaction(OP_ACK, 32'hFFFF_FFFF);
    program_thresholds(8'd1, 4'd1);
    offer_transaction(OP_TICK, 32'h0);          // resend
    offer_transaction(OP_TICK, 32'h0);          // give up
    // fill in descending id order so slot order differs from id order
    for (int k = 15; k >= 0; k--) offer_transaction(OP_SEND, 32'h1111_1111 * k);
    offer_transaction(OP_SEND, 32'h5A5A_5A5A);  // table full
    offer_transaction(OP_TICK, 32'h0);          // every slot resends
    offer_transaction(OP_ACK, 32'h1111_1111);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        snd_idle = 11;
        rcv_idle = 72;
      end else if (p < 5) begin
        snd_idle = 72;
        rcv_idle = 11;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      program_thresholds(phase_timeout[p], phase_limit[p]);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        if (roll < 40) op = OP_SEND;
        else if (roll < 65) op = OP_ACK;
        else if (roll < 96) op = OP_TICK;
        else op = OP_RSVD;
        if (op != OP_RSVD) counted++;
        offer_transaction(op, id);
      end
    end

    drain_tracker();
    $display("Covered %0d transactions over %0d threshold settings and three idle mixes.",
             transactions, settings_used);
    $display("Checked %0d results, %0d of them resend or give-up events.",
             results_checked, expiry_events);
    if (fail_count == 0 && pending == 0)
      $display("PASS ack_retransmit_tracker_unit");
    else
      $display("FAIL ack_retransmit_tracker_unit");
    $finish;
  end

endmodule
